@@ hw/rtl/dqu_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue shared definitions
// Request and response types, request and status codes, and cell controls.
// ----------------------------------------------------------------------------
package dqu_pkg;

	localparam int unsigned DEPTH  = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	typedef logic [2:0] req_code_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] cell_op_t;

	localparam req_code_t REQ_PUSH_FRONT = 3'd0;
	localparam req_code_t REQ_PUSH_BACK  = 3'd1;
	localparam req_code_t REQ_POP_FRONT  = 3'd2;
	localparam req_code_t REQ_POP_BACK   = 3'd3;
	localparam req_code_t REQ_PEEK       = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam cell_op_t OP_HOLD   = 2'd0;
	localparam cell_op_t OP_INSERT = 2'd1;
	localparam cell_op_t OP_REMOVE = 2'd2;
	localparam cell_op_t OP_APPEND = 2'd3;

	typedef struct packed {
		req_code_t         req_type;
		logic [DATA_W-1:0] push_data;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] front_data;
		logic [DATA_W-1:0] back_data;
		logic [CNT_W-1:0]  item_count;
		logic              is_empty;
	} rsp_t;

	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] wdata;
		logic [CNT_W-1:0]  cnt;
	} chain_ctrl_t;

endpackage

@@ hw/rtl/dqu_cell.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue storage cell
// One word of a chain; shifts in from either neighbor or loads the push word.
// ----------------------------------------------------------------------------
module dqu_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                       clk,
	input  dqu_pkg::chain_ctrl_t       ctrl,
	input  logic [dqu_pkg::DATA_W-1:0] left_data,
	input  logic [dqu_pkg::DATA_W-1:0] right_data,
	output logic [dqu_pkg::DATA_W-1:0] data
);

	localparam logic [dqu_pkg::CNT_W-1:0] POS = IDX[dqu_pkg::CNT_W-1:0];

	logic [dqu_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			dqu_pkg::OP_INSERT: data_q <= left_data;
			dqu_pkg::OP_REMOVE: data_q <= right_data;
			dqu_pkg::OP_APPEND: begin
				if (ctrl.cnt == POS) begin
					data_q <= ctrl.wdata;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

@@ hw/rtl/dqu_chain.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue cell chain
// A row of cells with its head word at cell zero.
// ----------------------------------------------------------------------------
module dqu_chain (
	input  logic                       clk,
	input  dqu_pkg::chain_ctrl_t       ctrl,
	output logic [dqu_pkg::DATA_W-1:0] head
);

	logic [dqu_pkg::DATA_W-1:0] cell_data [dqu_pkg::DEPTH];

	for (genvar i = 0; i < dqu_pkg::DEPTH; i++) begin : g_cell
		logic [dqu_pkg::DATA_W-1:0] left_w;
		logic [dqu_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = ctrl.wdata;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == dqu_pkg::DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		dqu_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of words with push and pop at both ends.
// ----------------------------------------------------------------------------
// A request transfer takes place at a clock edge with start high and busy low.
// busy stays low, so a request may be given in every cycle.
// Each request gives one response, shown on rsp for exactly one cycle with
// done high, in the cycle after the request transfer. The response carries
// the status, the front and back words, the count and an empty flag as they
// stand after that request. The receiver cannot stall; a response is taken
// in the cycle it is shown.
// Throughput is one request per cycle, and the cell chains form a single
// register stage. The words are held in two chains of cells, one in
// front-to-back order and one in back-to-front order, so both end words
// always sit in a fixed cell.
// Reset clears the count and the response strobe; the queue starts empty and
// stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dqu_pkg::req_t req,
	output logic          done,
	output dqu_pkg::rsp_t rsp
);

	localparam logic [dqu_pkg::CNT_W-1:0] FULL_CNT = dqu_pkg::CNT_W'(dqu_pkg::DEPTH);

	logic                       accept;
	logic [dqu_pkg::CNT_W-1:0]  count_q;
	logic [dqu_pkg::CNT_W-1:0]  count_d;
	dqu_pkg::status_t           status_q;
	dqu_pkg::status_t           status_d;
	logic                       done_q;
	dqu_pkg::cell_op_t          f_op;
	dqu_pkg::cell_op_t          b_op;
	dqu_pkg::chain_ctrl_t       f_ctrl;
	dqu_pkg::chain_ctrl_t       b_ctrl;
	logic [dqu_pkg::DATA_W-1:0] f_head;
	logic [dqu_pkg::DATA_W-1:0] b_head;
	logic                       q_full;
	logic                       q_empty;

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign q_full  = (count_q == FULL_CNT);
	assign q_empty = (count_q == '0);

	always_comb begin
		f_op     = dqu_pkg::OP_HOLD;
		b_op     = dqu_pkg::OP_HOLD;
		status_d = dqu_pkg::ST_OK;
		count_d  = count_q;
		if (accept) begin
			case (req.req_type)
				dqu_pkg::REQ_PUSH_FRONT: begin
					if (q_full) begin
						status_d = dqu_pkg::ST_FULL;
					end else begin
						f_op    = dqu_pkg::OP_INSERT;
						b_op    = dqu_pkg::OP_APPEND;
						count_d = count_q + 1'b1;
					end
				end
				dqu_pkg::REQ_PUSH_BACK: begin
					if (q_full) begin
						status_d = dqu_pkg::ST_FULL;
					end else begin
						f_op    = dqu_pkg::OP_APPEND;
						b_op    = dqu_pkg::OP_INSERT;
						count_d = count_q + 1'b1;
					end
				end
				dqu_pkg::REQ_POP_FRONT: begin
					if (q_empty) begin
						status_d = dqu_pkg::ST_EMPTY;
					end else begin
						f_op    = dqu_pkg::OP_REMOVE;
						count_d = count_q - 1'b1;
					end
				end
				dqu_pkg::REQ_POP_BACK: begin
					if (q_empty) begin
						status_d = dqu_pkg::ST_EMPTY;
					end else begin
						b_op    = dqu_pkg::OP_REMOVE;
						count_d = count_q - 1'b1;
					end
				end
				default: status_d = dqu_pkg::ST_OK;
			endcase
		end
	end

	assign f_ctrl = '{op: f_op, wdata: req.push_data, cnt: count_q};
	assign b_ctrl = '{op: b_op, wdata: req.push_data, cnt: count_q};

	dqu_chain u_front_chain (
		.clk  (clk),
		.ctrl (f_ctrl),
		.head (f_head)
	);

	dqu_chain u_back_chain (
		.clk  (clk),
		.ctrl (b_ctrl),
		.head (b_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	assign done           = done_q;
	assign rsp.status     = status_q;
	assign rsp.front_data = q_empty ? '0 : f_head;
	assign rsp.back_data  = q_empty ? '0 : b_head;
	assign rsp.item_count = count_q;
	assign rsp.is_empty   = q_empty;

endmodule

@@ hw/rtl/dqu_checker.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Checks response timing and consistency seen on the top level ports.
// ----------------------------------------------------------------------------
module dqu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input dqu_pkg::req_t req,
	input logic          done,
	input dqu_pkg::rsp_t rsp
);

	a_one_rsp_per_req: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (done == $past(start && !busy)))
		else $error("response strobe does not follow a request transfer");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.item_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.is_empty) |-> (rsp.front_data == '0 && rsp.back_data == '0))
		else $error("words shown on an empty queue");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == dqu_pkg::ST_FULL)
			|-> (rsp.item_count == dqu_pkg::CNT_W'(dqu_pkg::DEPTH)))
		else $error("full status reported below capacity");

	a_push_data_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == dqu_pkg::REQ_PUSH_FRONT)
			|=> (rsp.status == dqu_pkg::ST_FULL || rsp.front_data == $past(req.push_data)))
		else $error("pushed front word not shown at the front");

endmodule

bind double_ended_queue_unit dqu_checker u_dqu_checker (.*);
